### rtl/fkg_pkg.sv
// Shared types and constants for the Fish keystream generator.
// No dependencies; every rtl file imports this package.
package fkg_pkg;

  localparam int RING_LEN = 56;
  localparam int IDX_W    = 6;
  localparam int WORD_W   = 32;

  localparam logic [IDX_W-1:0] LAST_POS = IDX_W'(RING_LEN - 1);

  // Tap places in the shift chain, relative to the cell at the current position.
  localparam int A_TAP_NEAR = 1;
  localparam int A_TAP_FAR  = 32;
  localparam int B_TAP_NEAR = 4;
  localparam int B_TAP_FAR  = 37;

  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_STEP = 1'b1;

  localparam logic RING_SEL_A = 1'b0;
  localparam logic RING_SEL_B = 1'b1;

  typedef logic [WORD_W-1:0] word_t;
  typedef logic [IDX_W-1:0]  idx_t;

  // Control for one ring chain.
  typedef struct packed {
    logic  advance;
    logic  load;
    idx_t  idx;
    word_t word;
  } ring_ctl_t;

  // Control for the pair combiner.
  typedef struct packed {
    logic step;
    logic clear;
  } pair_ctl_t;

endpackage

### rtl/fkg_cell.sv
// One cell of a generator ring: a 32-bit word that takes its neighbor's word
// on advance, or a key word on load. Depends on fkg_pkg.
module fkg_cell (
  input  logic          clk,
  input  logic          advance,
  input  logic          load,
  input  fkg_pkg::word_t shift_in,
  input  fkg_pkg::word_t load_word,
  output fkg_pkg::word_t q
);
  import fkg_pkg::*;

  always_ff @(posedge clk) begin
    if (load) begin
      q <= load_word;
    end else if (advance) begin
      q <= shift_in;
    end
  end

endmodule

### rtl/fkg_chain.sv
// Row of RING_LEN cells forming one lagged-generator ring as a shift chain.
// Cell k holds the ring word k+1 places past the current position.
// Depends on fkg_pkg and fkg_cell.
module fkg_chain (
  input  logic                 clk,
  input  fkg_pkg::ring_ctl_t   ctl,
  input  fkg_pkg::word_t       tail,
  output fkg_pkg::word_t       words [fkg_pkg::RING_LEN]
);
  import fkg_pkg::*;

  for (genvar i = 0; i < RING_LEN; i++) begin : g_cell
    word_t shift_in;
    logic  we;

    if (i == RING_LEN - 1) begin : g_tail
      assign shift_in = tail;
    end else begin : g_mid
      assign shift_in = words[i+1];
    end

    // Out-of-range indexes match no cell.
    assign we = ctl.load && (ctl.idx == IDX_W'(i));

    fkg_cell u_cell (
      .clk       (clk),
      .advance   (ctl.advance),
      .load      (we),
      .shift_in  (shift_in),
      .load_word (ctl.word),
      .q         (words[i])
    );
  end

endmodule

### rtl/fkg_pair.sv
// Shrinking and combining stage: drops pairs with odd B word, holds the first
// kept pair, combines with the second into the output register. Depends on fkg_pkg.
module fkg_pair (
  input  logic               clk,
  input  logic               rst,
  input  fkg_pkg::pair_ctl_t ctl,
  input  fkg_pkg::word_t     z,
  input  fkg_pkg::word_t     h,
  output logic               m_tvalid,
  input  logic               m_tready,
  output logic [63:0]        m_tdata
);
  import fkg_pkg::*;

  logic  pair_phase;
  word_t held_z;
  word_t held_h;
  word_t c;
  word_t d;

  assign c = held_z ^ (held_h & h);
  assign d = h & (c ^ z);

  always_ff @(posedge clk) begin
    if (rst) begin
      pair_phase <= 1'b0;
      m_tvalid   <= 1'b0;
    end else begin
      if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      if (ctl.clear) begin
        pair_phase <= 1'b0;
      end else if (ctl.step && !h[0]) begin
        if (!pair_phase) begin
          held_z     <= z;
          held_h     <= h;
          pair_phase <= 1'b1;
        end else begin
          pair_phase <= 1'b0;
          m_tvalid   <= 1'b1;
          m_tdata    <= {z ^ d, c ^ d};
        end
      end
    end
  end

endmodule

### rtl/fish_keystream_generator_unit.sv
// Top level of the Fish keystream generator: two shift-chain rings, position
// tracking and the pair combiner. Depends on fkg_pkg, fkg_chain, fkg_pair.
//
// Channel  Dir  Handshake          Payload
// s_*      in   s_tvalid/s_tready  tuser: operation, ring_select; tdata: key_index, key_word
// m_*      out  m_tvalid/m_tready  tdata: word_first, word_second
//
// One item per cycle: a step shifts both chains by one cell and sums fixed taps.
// A load taken after steps first waits while the chains rotate back to the
// home alignment, one cell per cycle; loads in a row then go one per cycle.
// rst restores position 55 and clears the pair phase and output valid; ring
// contents are not cleared. Steps stall only while the output register holds
// an untaken transaction.
module fish_keystream_generator_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [1:0]  s_tuser,   // [0] operation, [1] ring_select
  input  logic [39:0] s_tdata,   // [5:0] key_index, [37:6] key_word, [39:38] zero
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [63:0] m_tdata    // [31:0] word_first, [63:32] word_second
);
  import fkg_pkg::*;

  idx_t      pos;
  logic      pos_home;
  logic      is_load;
  logic      out_free;
  logic      accept;
  logic      step;
  logic      load;
  logic      rotate;
  word_t     sum_a;
  word_t     sum_b;
  ring_ctl_t ctl_a;
  ring_ctl_t ctl_b;
  pair_ctl_t pair_ctl;
  word_t     words_a [RING_LEN];
  word_t     words_b [RING_LEN];

  assign pos_home = (pos == LAST_POS);
  assign is_load  = (s_tuser[0] == OP_LOAD);
  assign out_free = !m_tvalid || m_tready;
  assign s_tready = is_load ? pos_home : out_free;
  assign accept   = s_tvalid && s_tready;
  assign step     = accept && !is_load;
  assign load     = accept && is_load;
  // Realign the chains so that cell k holds ring entry k before a load.
  assign rotate   = s_tvalid && is_load && !pos_home;

  assign sum_a = words_a[A_TAP_NEAR] + words_a[A_TAP_FAR];
  assign sum_b = words_b[B_TAP_NEAR] + words_b[B_TAP_FAR];

  always_comb begin
    ctl_a.advance = step || rotate;
    ctl_a.load    = load && (s_tuser[1] == RING_SEL_A);
    ctl_a.idx     = s_tdata[5:0];
    ctl_a.word    = s_tdata[37:6];
    ctl_b.advance = step || rotate;
    ctl_b.load    = load && (s_tuser[1] == RING_SEL_B);
    ctl_b.idx     = s_tdata[5:0];
    ctl_b.word    = s_tdata[37:6];
    pair_ctl.step  = step;
    pair_ctl.clear = load;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos <= LAST_POS;
    end else if (step || rotate) begin
      pos <= pos_home ? '0 : pos + 1'b1;
    end
  end

  fkg_chain u_chain_a (
    .clk   (clk),
    .ctl   (ctl_a),
    .tail  (step ? sum_a : words_a[0]),
    .words (words_a)
  );

  fkg_chain u_chain_b (
    .clk   (clk),
    .ctl   (ctl_b),
    .tail  (step ? sum_b : words_b[0]),
    .words (words_b)
  );

  fkg_pair u_pair (
    .clk      (clk),
    .rst      (rst),
    .ctl      (pair_ctl),
    .z        (sum_a),
    .h        (sum_b),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

`ifndef SYNTH
  a_pos_range: assert property (@(posedge clk) disable iff (rst)
    pos <= LAST_POS)
    else $error("position out of ring range");

  a_load_home: assert property (@(posedge clk) disable iff (rst)
    load |-> pos_home)
    else $error("load taken while chains misaligned");

  a_rotate_idle: assert property (@(posedge clk) disable iff (rst)
    rotate |-> !accept)
    else $error("rotation overlaps an accepted transaction");

  a_out_from_step: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(step))
    else $error("output transaction without a step");
`endif

endmodule

### dv/fish_keystream_generator_unit_test.sv
// Self-checking testbench for fish_keystream_generator_unit: a queue-fed stream
// driver, an output monitor and an in-bench predictor of both rings and pairing.
// Depends on fkg_pkg and the rtl top level.
`timescale 1ns / 100ps

module fish_keystream_generator_unit_test;
  import fkg_pkg::*;

  localparam int ITEM_GOAL      = 1700;
  localparam int PACE_SPAN      = 400;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int DRAIN_CYCLES   = 2 * RING_LEN + 8;
  localparam int REPORT_CAP     = 40;

  typedef enum logic [1:0] {PACE_NONE, PACE_SEND, PACE_RECV, PACE_BOTH} pace_t;

  typedef struct {
    logic  op;
    logic  sel;
    idx_t  idx;
    word_t word;
  } key_item_t;

  typedef struct {
    word_t first;
    word_t second;
  } keystream_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [1:0]  s_tuser = '0;   // [0] operation, [1] ring_select
  logic [39:0] s_tdata = '0;   // [5:0] key_index, [37:6] key_word, [39:38] zero
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [63:0] m_tdata;        // [31:0] word_first, [63:32] word_second

  fish_keystream_generator_unit u_top (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  key_item_t  pending_q[$];
  keystream_t keystream_q[$];
  key_item_t  cur;

  // predictor state
  word_t key_ring_a [RING_LEN];
  word_t key_ring_b [RING_LEN];
  idx_t  ring_pos  = LAST_POS;
  logic  pair_held = 1'b0;
  word_t held_z, held_h;

  int n_total, n_accepted, n_loads, n_oor, n_steps, n_dropped, n_results, mismatches;
  int stall_cycles;
  pace_t pace;

  assign pace = pace_t'((n_accepted / PACE_SPAN) % 4);

  initial begin
    forever #5 clk = ~clk;
  end

  task automatic fish_predict(input key_item_t it);
    int unsigned p;
    word_t z, h, c, d;
    keystream_t ks;
    if (it.op == OP_LOAD) begin
      n_loads++;
      if (it.idx < RING_LEN) begin
        if (it.sel == RING_SEL_A) key_ring_a[it.idx] = it.word;
        else key_ring_b[it.idx] = it.word;
      end else begin
        n_oor++;
      end
      ring_pos  = LAST_POS;
      pair_held = 1'b0;
    end else begin
      n_steps++;
      p = (int'(ring_pos) + 1) % RING_LEN;
      ring_pos = idx_t'(p);
      z = key_ring_a[(p + A_TAP_NEAR) % RING_LEN] + key_ring_a[(p + A_TAP_FAR) % RING_LEN];
      h = key_ring_b[(p + B_TAP_NEAR) % RING_LEN] + key_ring_b[(p + B_TAP_FAR) % RING_LEN];
      key_ring_a[p] = z;
      key_ring_b[p] = h;
      if (h[0]) begin
        n_dropped++;
      end else if (!pair_held) begin
        held_z    = z;
        held_h    = h;
        pair_held = 1'b1;
      end else begin
        pair_held = 1'b0;
        c = held_z ^ (held_h & h);
        d = h & (c ^ z);
        ks.first  = c ^ d;
        ks.second = z ^ d;
        keystream_q.push_back(ks);
      end
    end
  endtask

  task automatic report_mismatch(input string what, input word_t got, input word_t want);
    mismatches++;
    if (mismatches <= REPORT_CAP)
      $display("%0t mismatch %s: got %08h want %08h", $realtime, what, got, want);
  endtask

  function automatic bit sender_pause();
    case (pace)
      PACE_SEND: return $urandom_range(99) < 86;
      PACE_BOTH: return $urandom_range(99) < 23;
      default:   return 1'b0;
    endcase
  endfunction

  function automatic bit receiver_pause();
    case (pace)
      PACE_RECV: return $urandom_range(99) < 86;
      PACE_BOTH: return $urandom_range(99) < 23;
      default:   return 1'b0;
    endcase
  endfunction

  task automatic push_load(input logic sel, input idx_t idx, input word_t word);
    key_item_t it;
    it.op   = OP_LOAD;
    it.sel  = sel;
    it.idx  = idx;
    it.word = word;
    pending_q.push_back(it);
  endtask

  task automatic push_step(input logic sel, input idx_t idx, input word_t word);
    key_item_t it;
    it.op   = OP_STEP;
    it.sel  = sel;
    it.idx  = idx;
    it.word = word;
    pending_q.push_back(it);
  endtask

  // Full key: every entry of both rings, with the word extremes at the ends.
  task automatic push_rekey();
    word_t wa, wb;
    for (int i = 0; i < RING_LEN; i++) begin
      wa = $urandom;
      wb = $urandom;
      if (i == 0) begin
        wa = '0;
        wb = '1;
      end else if (i == RING_LEN - 1) begin
        wa = '1;
        wb = '0;
      end
      push_load(RING_SEL_A, idx_t'(i), wa);
      push_load(RING_SEL_B, idx_t'(i), wb);
    end
  endtask

  // Driver: offers the head of pending_q, predicts on each accepted transaction.
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) begin
        fish_predict(cur);
        n_accepted++;
      end
      if (!s_tvalid || s_tready) begin
        if (pending_q.size() != 0 && !sender_pause()) begin
          cur = pending_q.pop_front();
          s_tuser  <= {cur.sel, cur.op};
          s_tdata  <= {2'b00, cur.word, cur.idx};
          s_tvalid <= 1'b1;
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // Monitor: compares each output transaction with the oldest expected pair.
  always @(posedge clk) begin
    keystream_t ks;
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        n_results++;
        if (keystream_q.size() == 0) begin
          report_mismatch("unexpected output", m_tdata[WORD_W-1:0], '0);
        end else begin
          ks = keystream_q.pop_front();
          if (m_tdata[WORD_W-1:0] !== ks.first)
            report_mismatch("word_first", m_tdata[WORD_W-1:0], ks.first);
          if (m_tdata[2*WORD_W-1:WORD_W] !== ks.second)
            report_mismatch("word_second", m_tdata[2*WORD_W-1:WORD_W], ks.second);
        end
      end
      m_tready <= !receiver_pause();
    end
  end

  // Watchdog on cycles without any transaction on either side.
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no transaction for %0d cycles, %0d of %0d items in, %0d pending out",
               stall_cycles, n_accepted, n_total, keystream_q.size());
      $display("status: fail");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    int r;
    int n;
    // out-of-range loads before any key: nothing written
    push_load(RING_SEL_A, idx_t'(RING_LEN), '1);
    push_load(RING_SEL_B, '1, '1);
    // steps read only after every ring entry holds a key word
    push_rekey();
    push_step(1'b0, '0, '0);
    push_step(1'b1, '1, '1);
    repeat (10) push_step(1'($urandom), idx_t'($urandom), $urandom);
    // loads after steps force the rotation back home; phase is cleared
    push_load(RING_SEL_A, '0, '1);
    push_load(RING_SEL_B, LAST_POS, '0);
    push_load(RING_SEL_A, '1, '1);
    repeat (6) push_step(1'($urandom), idx_t'($urandom), $urandom);

    while (pending_q.size() < ITEM_GOAL) begin
      r = $urandom_range(99);
      if (r < 85) begin
        n = $urandom_range(1, 40);
        repeat (n) push_step(1'($urandom), idx_t'($urandom), $urandom);
      end else if (r < 95) begin
        n = $urandom_range(1, 6);
        repeat (n) push_load(1'($urandom), idx_t'($urandom_range(63)), $urandom);
      end else begin
        push_rekey();
      end
    end
    n_total = pending_q.size();

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    while (n_accepted < n_total) @(posedge clk);
    while (keystream_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("covered %0d loads (%0d out of range) and %0d steps (%0d odd pairs dropped)",
             n_loads, n_oor, n_steps, n_dropped);
    $display("checked %0d keystream transactions, %0d mismatches", n_results, mismatches);
    if (mismatches == 0 && keystream_q.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
